FILE: rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types and constants of the radix digit emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int RADIX_WIDTH = 5;
    localparam int DIGIT_WIDTH = 4;
    localparam int CHAR_WIDTH  = 7;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
    localparam int BIT_WIDTH   = $clog2(VALUE_WIDTH);

    localparam logic [CHAR_WIDTH-1:0]  DIGIT_ZERO  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0]  DIGIT_ALPHA = 7'd65;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 5'd16;
    localparam logic [DIGIT_WIDTH:0]   DECIMAL_TEN = 5'd10;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_WIDTH-1:0] radix;
    } arg_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0]  digit_char;
        logic [DIGIT_WIDTH-1:0] digit_value;
        logic                   last;
    } digit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_WIDTH-1:0] ascii_of(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] wide;
        wide = {{(CHAR_WIDTH - DIGIT_WIDTH){1'b0}}, d};
        if ({1'b0, d} < DECIMAL_TEN)
            ascii_of = DIGIT_ZERO + wide;
        else
            ascii_of = DIGIT_ALPHA + wide - CHAR_WIDTH'(DECIMAL_TEN);
    endfunction

endpackage

FILE: rtl/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts a binary value to ASCII digits in a base from two to sixteen.
// ----------------------------------------------------------------------------
// Usage: a request on the arg channel carries a value and a base. The block
// divides the value by the base with a bit-serial restoring divider, one
// quotient bit per cycle, and pushes each remainder onto a digit stack. When
// the quotient reaches zero it pops the stack onto the digit channel, most
// significant digit first, with last set on the final digit. A zero value
// yields the single digit '0'. Bases below two count as two, above sixteen
// as sixteen.
// Each digit takes the divider through all VALUE_WIDTH (31) quotient bits; once
// the quotient reaches zero, digit_valid rises and the block moves one digit
// per cycle while the receiver is ready. No new request is taken until the
// final digit is taken; arg_ready is high only while the block is idle.
// Reset clears the state machine and digit count; the block comes up idle.
// A stalled receiver holds the current digit on the port until it is taken.
// ----------------------------------------------------------------------------
module radix_digit_emitter
    import rde_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   arg_valid,
    output logic   arg_ready,
    input  arg_t   arg,
    output logic   digit_valid,
    input  logic   digit_ready,
    output digit_t digit
);

    state_t                  state_reg, state_next;
    logic [CNT_WIDTH-1:0]    count_reg, count_next;
    logic [BIT_WIDTH-1:0]    bit_reg, bit_next;
    logic [VALUE_WIDTH-1:0]  quot_reg, quot_next;
    logic [DIGIT_WIDTH-1:0]  rem_reg, rem_next;
    logic [RADIX_WIDTH-1:0]  radix_reg, radix_next;
    logic [DIGIT_WIDTH-1:0]  stack_reg [VALUE_WIDTH];
    logic [DIGIT_WIDTH-1:0]  stack_next [VALUE_WIDTH];

    logic [DIGIT_WIDTH:0]    trial;
    logic                    fits;
    logic [DIGIT_WIDTH-1:0]  rem_step;
    logic [VALUE_WIDTH-1:0]  quot_step;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[VALUE_WIDTH-1]};
        fits      = (trial >= radix_reg);
        rem_step  = fits ? DIGIT_WIDTH'(trial - radix_reg) : trial[DIGIT_WIDTH-1:0];
        quot_step = {quot_reg[VALUE_WIDTH-2:0], fits};
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        bit_next    = bit_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        stack_next  = stack_reg;
        arg_ready   = 1'b0;
        digit_valid = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                arg_ready = 1'b1;
                if (arg_valid)
                begin
                    quot_next  = arg.value;
                    rem_next   = '0;
                    bit_next   = '0;
                    count_next = '0;
                    if (arg.radix < RADIX_MIN)
                        radix_next = RADIX_MIN;
                    else if (arg.radix > RADIX_MAX)
                        radix_next = RADIX_MAX;
                    else
                        radix_next = arg.radix;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                quot_next = quot_step;
                if (bit_reg == BIT_WIDTH'(VALUE_WIDTH - 1))
                begin
                    for (int i = VALUE_WIDTH - 1; i > 0; i--)
                        stack_next[i] = stack_reg[i-1];
                    stack_next[0] = rem_step;
                    count_next    = count_reg + 1'b1;
                    rem_next      = '0;
                    bit_next      = '0;
                    if (quot_step == '0)
                        state_next = ST_EMIT;
                end
                else
                begin
                    rem_next = rem_step;
                    bit_next = bit_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                digit_valid = 1'b1;
                if (digit_ready)
                begin
                    for (int i = 0; i < VALUE_WIDTH - 1; i++)
                        stack_next[i] = stack_reg[i+1];
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_WIDTH'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign digit.digit_value = stack_reg[0];
    assign digit.digit_char  = ascii_of(stack_reg[0]);
    assign digit.last        = (count_reg == CNT_WIDTH'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        stack_reg <= stack_next;
    end

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (count_reg != '0))
        else $error("digit offered with an empty digit stack");

    a_request_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (arg_valid && arg_ready) |=> (state_reg == ST_DIVIDE && count_reg == '0))
        else $error("accepted request did not start the divider");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && digit_ready && digit.last) |=> (arg_ready && !digit_valid))
        else $error("block not idle after the final digit");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        arg_ready |-> !digit_valid)
        else $error("new request accepted while digits are pending");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit emitter testbench
// Sends conversion requests (a directed set, then random ones) with random
// gaps, stalls the digit channel at random, and checks every digit against
// a local model of repeated division, most significant digit first.
// ----------------------------------------------------------------------------
module testbench
    import rde_pkg::*;
();

    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX    = {VALUE_WIDTH{1'b1}};
    localparam int                     RANDOM_ITEMS = 440;
    localparam int                     DRAIN_CYCLES = 64;

    typedef struct {
        arg_t        req;
        int unsigned gap;
        bit          drain;
    } pending_req_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   arg_valid   = 1'b0;
    logic   arg_ready;
    arg_t   arg         = '0;
    logic   digit_valid;
    logic   digit_ready = 1'b0;
    digit_t digit;

    pending_req_t pending_reqs[$];
    digit_t       expected_digits[$];

    logic [DIGIT_WIDTH-1:0] remainder_stack [VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0] quotient_copy   = '0;

    logic        arg_fire     = 1'b0;
    int unsigned req_total    = 0;
    int unsigned req_accepted = 0;
    int unsigned error_count  = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned rx_mode_left = 0;
    bit          rx_lively    = 1'b0;
    bit          tx_lively    = 1'b1;

    radix_digit_emitter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .arg_valid   (arg_valid),
        .arg_ready   (arg_ready),
        .arg         (arg),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit)
    );

    always #10 clk = ~clk;

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    task automatic queue_req(input logic [VALUE_WIDTH-1:0] value,
                             input logic [RADIX_WIDTH-1:0] radix, input bit drain);
        pending_req_t p;
        p.req.value = value;
        p.req.radix = radix;
        p.drain     = drain;
        if (!tx_lively || $urandom_range(0, 9) < 4)
            p.gap = 0;
        else
            p.gap = pick_len();
        pending_reqs = {pending_reqs, p};
        req_total++;
    endtask

    task automatic predict_digits(input arg_t req);
        logic [RADIX_WIDTH-1:0] base;
        logic [DIGIT_WIDTH-1:0] d;
        digit_t                 e;
        int                     n;
        if (req.radix < RADIX_MIN)
            base = RADIX_MIN;
        else if (req.radix > RADIX_MAX)
            base = RADIX_MAX;
        else
            base = req.radix;
        quotient_copy = req.value;
        n = 0;
        if (quotient_copy == '0)
        begin
            remainder_stack[0] = '0;
            n = 1;
        end
        else
        begin
            while (quotient_copy != '0 && n < VALUE_WIDTH)
            begin
                remainder_stack[n] = DIGIT_WIDTH'(quotient_copy % base);
                quotient_copy = quotient_copy / base;
                n++;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            d = remainder_stack[n - 1 - k];
            e.digit_value = d;
            if ({1'b0, d} < DECIMAL_TEN)
                e.digit_char = DIGIT_ZERO + CHAR_WIDTH'(d);
            else
                e.digit_char = DIGIT_ALPHA + CHAR_WIDTH'(d) - CHAR_WIDTH'(DECIMAL_TEN);
            e.last = (k == n - 1);
            expected_digits = {expected_digits, e};
        end
    endtask

    task automatic report_mismatch(input string what, input digit_t got, input digit_t want);
        $display("%0t ns: %s: got char %0d value %0d last %0b, want char %0d value %0d last %0b",
                 $time, what, got.digit_char, got.digit_value, got.last,
                 want.digit_char, want.digit_value, want.last);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        digit_t want;
        arg_fire <= arg_valid && arg_ready;
        if (rst_n && arg_valid && arg_ready)
        begin
            predict_digits(arg);
            req_accepted++;
        end
        if (rst_n && digit_valid && digit_ready)
        begin
            if (expected_digits.size() == 0)
            begin
                report_mismatch("digit with no request pending", digit, '0);
            end
            else
            begin
                want = expected_digits.pop_front();
                if (digit.digit_char !== want.digit_char)
                    report_mismatch("digit_char differs", digit, want);
                if (digit.digit_value !== want.digit_value)
                    report_mismatch("digit_value differs", digit, want);
                if (digit.last !== want.last)
                    report_mismatch("last differs", digit, want);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            arg_valid <= 1'b0;
        end
        else if (!(arg_valid && !arg_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                arg_valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0)
            begin
                arg_valid <= 1'b0;
            end
            else if (pending_reqs[0].drain && expected_digits.size() != 0)
            begin
                arg_valid <= 1'b0;
            end
            else
            begin
                arg       <= pending_reqs[0].req;
                arg_valid <= 1'b1;
                gap_left  = pending_reqs[0].gap;
                void'(pending_reqs.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            digit_ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_lively    = ($urandom_range(0, 2) != 0);
                rx_mode_left = $urandom_range(50, 400);
            end
            else
            begin
                rx_mode_left--;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                digit_ready <= 1'b0;
            end
            else if (rx_lively && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_len() - 1;
                digit_ready <= 1'b0;
            end
            else
            begin
                digit_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_WIDTH-1:0] radix;
        int unsigned            tx_mode_left;
        int unsigned            r;

        queue_req('0, 5'd10, 1'b0);
        queue_req('0, RADIX_MIN, 1'b0);
        queue_req(VALUE_MAX, RADIX_MIN, 1'b0);
        queue_req(VALUE_MAX, RADIX_MAX, 1'b0);
        queue_req(VALUE_MAX, 5'd10, 1'b0);
        queue_req(31'd1, RADIX_MAX, 1'b0);
        queue_req(31'd15, RADIX_MAX, 1'b0);
        queue_req(31'd10, 5'd11, 1'b0);
        queue_req(31'h7EDCBA98, RADIX_MAX, 1'b0);
        queue_req(31'h12345678, RADIX_MAX, 1'b0);
        queue_req(31'd1000, 5'd10, 1'b0);
        queue_req(VALUE_MAX, 5'd0, 1'b1);
        queue_req(31'd5, 5'd1, 1'b0);
        queue_req(VALUE_MAX, 5'd17, 1'b0);
        queue_req(VALUE_MAX, 5'd31, 1'b0);
        queue_req('0, 5'd31, 1'b0);
        queue_req('0, 5'd0, 1'b0);
        queue_req(31'h55555555, RADIX_MIN, 1'b0);
        queue_req(31'h2AAAAAAA, RADIX_MIN, 1'b0);
        queue_req(31'd1, RADIX_MIN, 1'b0);
        queue_req(31'd2, RADIX_MIN, 1'b1);
        queue_req(31'd4095, 5'd7, 1'b0);

        tx_mode_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (tx_mode_left == 0)
            begin
                tx_lively    = ($urandom_range(0, 2) != 0);
                tx_mode_left = $urandom_range(15, 60);
            end
            else
            begin
                tx_mode_left--;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                value = '0;
            else if (r < 40)
                value = VALUE_WIDTH'($urandom_range(1, 1000));
            else if (r < 60)
                value = VALUE_WIDTH'($urandom_range(0, 65535));
            else
                value = VALUE_WIDTH'($urandom());
            if ($urandom_range(0, 4) == 0)
                radix = RADIX_WIDTH'($urandom_range(0, 31));
            else
                radix = RADIX_WIDTH'($urandom_range(RADIX_MIN, RADIX_MAX));
            queue_req(value, radix, $urandom_range(0, 39) == 0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (req_accepted == req_total);
        wait (expected_digits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("timeout with %0d digits outstanding", expected_digits.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
